### rtl/dmwc_pkg.sv
// shared types and constants of the direct-mapped write-back cache
package dmwc_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BYTE_BITS  = 8;
    localparam int LANE_BITS  = 3;
    localparam int WORD_SHIFT = 3;

    typedef enum logic [1:0] {
        OP_READ       = 2'd0,
        OP_WRITE_BYTE = 2'd1,
        OP_WRITE_BACK = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    // operation part of a queued request
    typedef struct packed {
        op_t                  op;
        logic [LANE_BITS-1:0] lane;
        logic [BYTE_BITS-1:0] byte_value;
    } req_ctl_t;

    // status of the back end seen by the front end and the checks
    typedef struct packed {
        logic clearing;
        logic idle;
    } bk_status_t;

endpackage

### rtl/dmwc_front.sv
// front end: accepts requests, splits the address and queues them
module dmwc_front #(
    parameter int LINE_BYTES = 64,
    parameter int NUM_LINES  = 512,
    parameter int ADDR_BITS  = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [ADDR_BITS-1:0]              address,
    input  logic [dmwc_pkg::BYTE_BITS-1:0]    byte_value,
    input  logic [dmwc_pkg::WORD_BITS-1:0]    line_word,
    input  dmwc_pkg::bk_status_t              bk_status,
    input  logic                              q_pop,
    output logic                              q_valid,
    output dmwc_pkg::req_ctl_t                q_ctl,
    output logic [ADDR_BITS-$clog2(LINE_BYTES)-$clog2(NUM_LINES)-1:0] q_tag,
    output logic [$clog2(NUM_LINES)-1:0]      q_idx,
    output logic [(($clog2(LINE_BYTES) > 3) ? ($clog2(LINE_BYTES) - 3) : 1)-1:0] q_slot,
    output logic [dmwc_pkg::WORD_BITS-1:0]    q_word
);

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int IDX_BITS  = $clog2(NUM_LINES);
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int WB        = OFF_BITS - 3;
    localparam int SLOT_BITS = (WB > 0) ? WB : 1;
    localparam logic [SLOT_BITS-1:0] SLOT_MASK = SLOT_BITS'((1 << WB) - 1);

    logic [1:0]                    wr_ptr_reg, wr_ptr_next;
    logic [1:0]                    rd_ptr_reg, rd_ptr_next;
    dmwc_pkg::req_ctl_t            ctl_mem [2];
    logic [TAG_BITS-1:0]           tag_mem [2];
    logic [IDX_BITS-1:0]           idx_mem [2];
    logic [SLOT_BITS-1:0]          slot_mem [2];
    logic [dmwc_pkg::WORD_BITS-1:0] word_mem [2];

    logic                          full;
    logic                          push;
    dmwc_pkg::req_ctl_t            ctl_in;

    // two-entry queue, pointers carry a wrap bit
    assign full     = (wr_ptr_reg[0] == rd_ptr_reg[0]) && (wr_ptr_reg[1] != rd_ptr_reg[1]);
    assign q_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign in_stall = full || bk_status.clearing;

    // classify: the unused opcode is taken and dropped
    always_comb
    begin
        ctl_in.op         = dmwc_pkg::op_t'(opcode);
        ctl_in.lane       = address[dmwc_pkg::LANE_BITS-1:0];
        ctl_in.byte_value = byte_value;
        push = in_valid && !in_stall && (ctl_in.op != dmwc_pkg::OP_NONE);
    end

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 2'd1) : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? (rd_ptr_reg + 2'd1) : rd_ptr_reg;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg[0]]  <= ctl_in;
            tag_mem[wr_ptr_reg[0]]  <= address[ADDR_BITS-1:OFF_BITS+IDX_BITS];
            idx_mem[wr_ptr_reg[0]]  <= address[OFF_BITS+IDX_BITS-1:OFF_BITS];
            slot_mem[wr_ptr_reg[0]] <= SLOT_BITS'(address >> dmwc_pkg::WORD_SHIFT) & SLOT_MASK;
            word_mem[wr_ptr_reg[0]] <= line_word;
        end
    end

    assign q_ctl  = ctl_mem[rd_ptr_reg[0]];
    assign q_tag  = tag_mem[rd_ptr_reg[0]];
    assign q_idx  = idx_mem[rd_ptr_reg[0]];
    assign q_slot = slot_mem[rd_ptr_reg[0]];
    assign q_word = word_mem[rd_ptr_reg[0]];

endmodule

### rtl/dmwc_back.sv
// back end: tag check, victim copy-out, line fill, access and result beats
module dmwc_back #(
    parameter int LINE_BYTES = 64,
    parameter int NUM_LINES  = 512,
    parameter int ADDR_BITS  = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  dmwc_pkg::req_ctl_t                q_ctl,
    input  logic [ADDR_BITS-$clog2(LINE_BYTES)-$clog2(NUM_LINES)-1:0] q_tag,
    input  logic [$clog2(NUM_LINES)-1:0]      q_idx,
    input  logic [(($clog2(LINE_BYTES) > 3) ? ($clog2(LINE_BYTES) - 3) : 1)-1:0] q_slot,
    input  logic [dmwc_pkg::WORD_BITS-1:0]    q_word,
    output dmwc_pkg::bk_status_t              bk_status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dmwc_pkg::WORD_BITS-1:0]    read_word,
    output logic                              hit,
    output logic                              last
);

    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int IDX_BITS   = $clog2(NUM_LINES);
    localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int WB         = OFF_BITS - 3;
    localparam int WPL        = LINE_BYTES / 8;
    localparam int SLOT_BITS  = (WB > 0) ? WB : 1;
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int MEMA_BITS  = ADDR_BITS - 3;
    localparam int MEM_WORDS  = 1 << MEMA_BITS;
    localparam int LA_BITS    = IDX_BITS + WB;
    localparam int LINE_WORDS = NUM_LINES * WPL;
    localparam int TENT_BITS  = TAG_BITS + 2;
    localparam int WBITS      = dmwc_pkg::WORD_BITS;
    localparam int BBITS      = dmwc_pkg::BYTE_BITS;
    localparam logic [SLOT_BITS-1:0] SLOT_MASK = SLOT_BITS'((1 << WB) - 1);
    localparam logic [CNT_BITS-1:0]  CNT_WPL   = CNT_BITS'(WPL);
    localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(WPL - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EVICT,
        S_FILL,
        S_READ_RD,
        S_READ_OUT,
        S_WRITE_RD,
        S_WRITE_DO
    } state_t;

    state_t                  state_reg, state_next;
    logic [MEMA_BITS-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    pend_reg, pend_next;
    dmwc_pkg::req_ctl_t      ctl_reg, ctl_next;
    logic [TAG_BITS-1:0]     tag_reg, tag_next;
    logic [IDX_BITS-1:0]     idx_reg, idx_next;
    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic [WBITS-1:0]        word_reg, word_next;
    logic                    hit_reg, hit_next;
    logic [TAG_BITS-1:0]     vtag_reg, vtag_next;
    logic                    out_valid_reg, out_valid_next;
    logic [WBITS-1:0]        out_word_reg, out_word_next;
    logic                    out_hit_reg, out_hit_next;
    logic                    out_last_reg, out_last_next;

    // memories and their ports
    logic [WBITS-1:0]        back_mem [MEM_WORDS];
    logic [WBITS-1:0]        line_mem [LINE_WORDS];
    logic [TENT_BITS-1:0]    tag_mem [NUM_LINES];
    logic [WBITS-1:0]        back_rdata_reg;
    logic [WBITS-1:0]        line_rdata_reg;
    logic [TENT_BITS-1:0]    tag_rdata_reg;
    logic                    back_we, line_we, tag_we;
    logic [MEMA_BITS-1:0]    back_waddr, back_raddr;
    logic [WBITS-1:0]        back_wdata, line_wdata;
    logic [LA_BITS-1:0]      line_waddr, line_raddr;
    logic [TENT_BITS-1:0]    tag_wdata;
    logic [IDX_BITS-1:0]     tag_waddr;

    logic                    out_free;
    logic                    lk_hit;
    logic [SLOT_BITS-1:0]    wi;
    logic [WBITS-1:0]        merged;

    function automatic logic [LA_BITS-1:0] laddr(input logic [IDX_BITS-1:0] i,
                                                 input logic [SLOT_BITS-1:0] s);
        return (LA_BITS'(i) << WB) | LA_BITS'(s & SLOT_MASK);
    endfunction

    function automatic logic [MEMA_BITS-1:0] maddr(input logic [TAG_BITS-1:0] t,
                                                   input logic [IDX_BITS-1:0] i,
                                                   input logic [SLOT_BITS-1:0] s);
        return (MEMA_BITS'({t, i}) << WB) | MEMA_BITS'(s & SLOT_MASK);
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign lk_hit   = tag_rdata_reg[TENT_BITS-1] && (tag_rdata_reg[TAG_BITS-1:0] == tag_reg);
    assign wi       = SLOT_BITS'(cnt_reg - CNT_BITS'(1));

    // byte merge into the addressed word, or the whole word for a write-back
    always_comb
    begin
        merged = line_rdata_reg;
        if (ctl_reg.op == dmwc_pkg::OP_WRITE_BYTE)
        begin
            for (int k = 0; k < WBITS / BBITS; k++)
            begin
                if (ctl_reg.lane == dmwc_pkg::LANE_BITS'(k))
                begin
                    merged[k*BBITS +: BBITS] = ctl_reg.byte_value;
                end
            end
        end
        else
        begin
            merged = word_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        ctl_next       = ctl_reg;
        tag_next       = tag_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        word_next      = word_reg;
        hit_next       = hit_reg;
        vtag_next      = vtag_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        out_hit_next   = out_hit_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        back_we        = 1'b0;
        back_waddr     = maddr(vtag_reg, idx_reg, wi);
        back_wdata     = line_rdata_reg;
        back_raddr     = maddr(tag_reg, idx_reg, cnt_reg[SLOT_BITS-1:0]);
        line_we        = 1'b0;
        line_waddr     = laddr(idx_reg, wi);
        line_wdata     = back_rdata_reg;
        line_raddr     = laddr(idx_reg, cnt_reg[SLOT_BITS-1:0]);
        tag_we         = 1'b0;
        tag_waddr      = idx_reg;
        tag_wdata      = {1'b1, 1'b0, tag_reg};

        case (state_reg)
            S_CLEAR:
            begin
                // zero the backing store and the tag entries
                back_we    = 1'b1;
                back_waddr = clr_cnt_reg;
                back_wdata = '0;
                if (clr_cnt_reg < MEMA_BITS'(NUM_LINES))
                begin
                    tag_we    = 1'b1;
                    tag_waddr = clr_cnt_reg[IDX_BITS-1:0];
                    tag_wdata = '0;
                end
                clr_cnt_next = clr_cnt_reg + MEMA_BITS'(1);
                if (clr_cnt_reg == MEMA_BITS'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ctl_next   = q_ctl;
                    tag_next   = q_tag;
                    idx_next   = q_idx;
                    slot_next  = q_slot;
                    word_next  = q_word;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                hit_next  = lk_hit;
                vtag_next = tag_rdata_reg[TAG_BITS-1:0];
                cnt_next  = '0;
                pend_next = 1'b0;
                if (lk_hit)
                begin
                    state_next = (ctl_reg.op == dmwc_pkg::OP_READ) ? S_READ_RD : S_WRITE_RD;
                end
                else if (tag_rdata_reg[TENT_BITS-1] && tag_rdata_reg[TENT_BITS-2])
                begin
                    state_next = S_EVICT;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_EVICT:
            begin
                // read line words, write each one in the next cycle
                pend_next = (cnt_reg < CNT_WPL);
                if (cnt_reg < CNT_WPL)
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
                back_we = pend_reg;
                if (pend_reg && (cnt_reg == CNT_WPL))
                begin
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                pend_next = (cnt_reg < CNT_WPL);
                if (cnt_reg < CNT_WPL)
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
                line_we = pend_reg;
                if (pend_reg && (cnt_reg == CNT_WPL))
                begin
                    tag_we     = 1'b1;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = (ctl_reg.op == dmwc_pkg::OP_READ) ? S_READ_RD : S_WRITE_RD;
                end
            end
            S_READ_RD:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = line_rdata_reg;
                    out_hit_next   = hit_reg;
                    out_last_next  = (cnt_reg == CNT_LAST);
                    cnt_next       = cnt_reg + CNT_BITS'(1);
                    state_next     = (cnt_reg == CNT_LAST) ? S_IDLE : S_READ_RD;
                end
            end
            S_WRITE_RD:
            begin
                line_raddr = laddr(idx_reg, slot_reg);
                state_next = S_WRITE_DO;
            end
            S_WRITE_DO:
            begin
                line_raddr = laddr(idx_reg, slot_reg);
                if (out_free)
                begin
                    line_we        = 1'b1;
                    line_waddr     = laddr(idx_reg, slot_reg);
                    line_wdata     = merged;
                    tag_we         = 1'b1;
                    tag_wdata      = {1'b1, 1'b1, tag_reg};
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    out_hit_next   = hit_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        ctl_reg      <= ctl_next;
        tag_reg      <= tag_next;
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        word_reg     <= word_next;
        hit_reg      <= hit_next;
        vtag_reg     <= vtag_next;
        out_word_reg <= out_word_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    // backing store
    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            back_mem[back_waddr] <= back_wdata;
        end
        back_rdata_reg <= back_mem[back_raddr];
    end

    // line data store
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        line_rdata_reg <= line_mem[line_raddr];
    end

    // tag store with valid and dirty marks, read at the queue head
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rdata_reg <= tag_mem[q_idx];
    end

    assign bk_status.clearing = (state_reg == S_CLEAR);
    assign bk_status.idle     = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign read_word = out_word_reg;
    assign hit       = out_hit_reg;
    assign last      = out_last_reg;

endmodule

### rtl/direct_mapped_writeback_cache_top.sv
// top level of the direct-mapped write-back cache with its backing store
// After reset the block zeroes its backing store and tag entries in one pass and
// holds in_stall high meanwhile. Requests are then taken into a two-entry queue
// and served one at a time by the back end. A write returns a single result beat,
// a line read returns LINE_BYTES/8 beats, each read through the registered read
// port of the line store. A miss first copies out a dirty victim, if any, then
// fills the line, one line word at a time through one memory port.
// Opcode 3 is taken and gives no result.
module direct_mapped_writeback_cache_top #(
    parameter int LINE_BYTES = 64,
    parameter int NUM_LINES  = 512,
    parameter int ADDR_BITS  = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     opcode,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic [dmwc_pkg::BYTE_BITS-1:0] byte_value,
    input  logic [dmwc_pkg::WORD_BITS-1:0] line_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dmwc_pkg::WORD_BITS-1:0] read_word,
    output logic                           hit,
    output logic                           last
);

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int IDX_BITS  = $clog2(NUM_LINES);
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int SLOT_BITS = (OFF_BITS > 3) ? (OFF_BITS - 3) : 1;

    dmwc_pkg::bk_status_t           bk_status;
    dmwc_pkg::req_ctl_t             q_ctl;
    logic                           q_valid;
    logic                           q_pop;
    logic [TAG_BITS-1:0]            q_tag;
    logic [IDX_BITS-1:0]            q_idx;
    logic [SLOT_BITS-1:0]           q_slot;
    logic [dmwc_pkg::WORD_BITS-1:0] q_word;

    // request intake and queue
    dmwc_front #(
        .LINE_BYTES (LINE_BYTES),
        .NUM_LINES  (NUM_LINES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .address    (address),
        .byte_value (byte_value),
        .line_word  (line_word),
        .bk_status  (bk_status),
        .q_pop      (q_pop),
        .q_valid    (q_valid),
        .q_ctl      (q_ctl),
        .q_tag      (q_tag),
        .q_idx      (q_idx),
        .q_slot     (q_slot),
        .q_word     (q_word)
    );

    // cache engine
    dmwc_back #(
        .LINE_BYTES (LINE_BYTES),
        .NUM_LINES  (NUM_LINES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_ctl      (q_ctl),
        .q_tag      (q_tag),
        .q_idx      (q_idx),
        .q_slot     (q_slot),
        .q_word     (q_word),
        .bk_status  (bk_status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_word  (read_word),
        .hit        (hit),
        .last       (last)
    );

`ifndef ASSERT_OFF
    // nothing is queued or delivered while the clearing pass runs
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.clearing |-> (!q_valid && !out_valid && in_stall))
        else $error("request activity during clearing pass");

    // the clearing pass hands over to the idle state
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(bk_status.clearing) |-> bk_status.idle)
        else $error("clearing pass did not end in idle");

    // the queue is only popped when the engine is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (bk_status.idle && q_valid))
        else $error("queue popped while engine busy");
`endif

endmodule

### sim/direct_mapped_writeback_cache_top_test.sv
// self-checking testbench for the direct-mapped write-back cache top level
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_top_test;

    localparam int LINE_BYTES = 64;
    localparam int NUM_LINES  = 512;
    localparam int ADDR_BITS  = 18;
    localparam int LINE_WORDS = LINE_BYTES / 8;
    localparam int MEM_DEPTH  = 1 << (ADDR_BITS - 3);
    localparam int IDX_BITS   = 9;
    localparam int OFS_BITS   = 6;
    localparam int TAG_BITS   = ADDR_BITS - IDX_BITS - OFS_BITS;
    localparam int STALL_LIMIT = 100000;

    typedef struct packed {
        dmwc_pkg::op_t        op;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           bval;
        logic [63:0]          word;
    } request_t;

    typedef struct packed {
        logic [63:0] data;
        logic        hit;
        logic        last;
    } beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] opcode;
    logic [ADDR_BITS-1:0] address;
    logic [7:0] byte_value;
    logic [63:0] line_word;
    logic out_valid;
    logic out_stall;
    logic [63:0] read_word;
    logic hit;
    logic last;

    direct_mapped_writeback_cache_top #(
        .LINE_BYTES(LINE_BYTES),
        .NUM_LINES(NUM_LINES),
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .address(address),
        .byte_value(byte_value), .line_word(line_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_word(read_word), .hit(hit), .last(last)
    );

    // cache model state
    logic [63:0]         cache_lines [NUM_LINES*LINE_WORDS];
    logic [TAG_BITS-1:0] line_tags [NUM_LINES];
    logic                line_valid [NUM_LINES];
    logic                line_dirty [NUM_LINES];
    logic [63:0]         main_mem [MEM_DEPTH];

    request_t pending_requests[$];
    beat_t    expected_beats[$];
    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int quiet_cycles;

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // work out the beats a request causes and update the model
    task automatic predict_request(input request_t r);
        logic [IDX_BITS-1:0] idx;
        logic [TAG_BITS-1:0] tg;
        logic [2:0] slot;
        logic [2:0] lane;
        logic was_hit;
        int base;
        beat_t b;
        idx  = r.addr[OFS_BITS +: IDX_BITS];
        tg   = r.addr[ADDR_BITS-1 -: TAG_BITS];
        slot = r.addr[5:3];
        lane = r.addr[2:0];
        if (r.op == dmwc_pkg::OP_NONE)
            return;
        was_hit = line_valid[idx] && line_tags[idx] == tg;
        if (!was_hit)
        begin
            // write back dirty victim, then fill
            if (line_valid[idx] && line_dirty[idx])
            begin
                base = {line_tags[idx], idx} * LINE_WORDS;
                for (int w = 0; w < LINE_WORDS; w++)
                    main_mem[base + w] = cache_lines[idx*LINE_WORDS + w];
            end
            base = {tg, idx} * LINE_WORDS;
            for (int w = 0; w < LINE_WORDS; w++)
                cache_lines[idx*LINE_WORDS + w] = main_mem[base + w];
            line_tags[idx]  = tg;
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b0;
        end
        if (r.op == dmwc_pkg::OP_READ)
        begin
            for (int w = 0; w < LINE_WORDS; w++)
            begin
                b.data = cache_lines[idx*LINE_WORDS + w];
                b.hit  = was_hit;
                b.last = (w == LINE_WORDS - 1);
                expected_beats.push_back(b);
            end
        end
        else
        begin
            if (r.op == dmwc_pkg::OP_WRITE_BYTE)
                cache_lines[idx*LINE_WORDS + slot][lane*8 +: 8] = r.bval;
            else
                cache_lines[idx*LINE_WORDS + slot] = r.word;
            line_dirty[idx] = 1'b1;
            b.data = '0;
            b.hit  = was_hit;
            b.last = 1'b1;
            expected_beats.push_back(b);
        end
    endtask

    function automatic request_t make_request(input dmwc_pkg::op_t op,
                                              input logic [ADDR_BITS-1:0] a);
        request_t r;
        r.op   = op;
        r.addr = a;
        r.bval = 8'($urandom);
        r.word = {$urandom, $urandom};
        return r;
    endfunction

    // driver: presents requests at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            opcode     <= '0;
            address    <= '0;
            byte_value <= '0;
            line_word  <= '0;
            out_stall  <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
            if (!(in_valid && in_stall))
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    opcode     <= pending_requests[0].op;
                    address    <= pending_requests[0].addr;
                    byte_value <= pending_requests[0].bval;
                    line_word  <= pending_requests[0].word;
                    void'(pending_requests.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on accepted requests, checks accepted beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && !in_stall)
            begin
                predict_request('{dmwc_pkg::op_t'(opcode), address, byte_value, line_word});
            end
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: word=%h hit=%b last=%b",
                                 read_word, hit, last);
                end
                else
                begin
                    if (read_word !== expected_beats[0].data || hit !== expected_beats[0].hit
                        || last !== expected_beats[0].last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected word=%h hit=%b last=%b, got %h %b %b",
                                     expected_beats[0].data, expected_beats[0].hit,
                                     expected_beats[0].last, read_word, hit, last);
                    end
                    void'(expected_beats.pop_front());
                end
            end
            // clearing pass after reset counts against the limit too
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("direct_mapped_writeback_cache_top verification failed");
                $finish;
            end
        end
    end

    // wait until the queue has drained and every beat has come
    task automatic drain_all();
        while (pending_requests.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
    endtask

    // random address; three times in four the index is drawn from a small pool to force conflicts
    function automatic logic [ADDR_BITS-1:0] pick_addr();
        logic [ADDR_BITS-1:0] a;
        a = ADDR_BITS'($urandom);
        if ($urandom_range(3) != 0)
            a[OFS_BITS +: IDX_BITS] = IDX_BITS'($urandom_range(7));
        return a;
    endfunction

    initial
    begin
        request_t r;
        int sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        address = '0;
        byte_value = '0;
        line_word = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tags[i]  = '0;
        end
        for (int i = 0; i < NUM_LINES*LINE_WORDS; i++)
            cache_lines[i] = '0;
        for (int i = 0; i < MEM_DEPTH; i++)
            main_mem[i] = '0;
        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        // directed: extremes, every opcode, hits, misses, dirty eviction, opcode 3
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, '0));
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, '0));
        r = make_request(dmwc_pkg::OP_WRITE_BYTE, '1);
        r.bval = 8'hff;
        pending_requests.push_back(r);
        r = make_request(dmwc_pkg::OP_WRITE_BYTE, 18'h00007);
        r.bval = 8'h00;
        pending_requests.push_back(r);
        r = make_request(dmwc_pkg::OP_WRITE_BACK, 18'h00038);
        r.word = '1;
        pending_requests.push_back(r);
        r = make_request(dmwc_pkg::OP_WRITE_BACK, 18'h00010);
        r.word = '0;
        pending_requests.push_back(r);
        pending_requests.push_back(make_request(dmwc_pkg::OP_NONE, 18'h00000));
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, 18'h08000));
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, 18'h00000));
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, '1));
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, 18'h07fc0));
        r = make_request(dmwc_pkg::OP_WRITE_BYTE, 18'h2aaaa);
        r.bval = 8'h55;
        pending_requests.push_back(r);
        r = make_request(dmwc_pkg::OP_WRITE_BACK, 18'h15555);
        r.word = 64'haaaa_aaaa_aaaa_aaaa;
        pending_requests.push_back(r);
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, 18'h2aa80));
        pending_requests.push_back(make_request(dmwc_pkg::OP_READ, 18'h15540));
        drain_all();

        // random phases: free, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 16 : 0;
            recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 16 : 0;
            for (int n = 0; n < 80; n++)
            begin
                sel = $urandom_range(19);
                r = make_request(sel < 8 ? dmwc_pkg::OP_READ :
                                 sel < 13 ? dmwc_pkg::OP_WRITE_BYTE :
                                 sel < 19 ? dmwc_pkg::OP_WRITE_BACK : dmwc_pkg::OP_NONE,
                                 pick_addr());
                pending_requests.push_back(r);
                // sender holds off until everything has come back
                if (n == 40)
                    drain_all();
            end
            drain_all();
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("direct_mapped_writeback_cache_top verification clean");
        else
            $display("direct_mapped_writeback_cache_top verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/dmwc_pkg.sv
rtl/dmwc_front.sv
rtl/dmwc_back.sv
rtl/direct_mapped_writeback_cache_top.sv
sim/direct_mapped_writeback_cache_top_test.sv
